// File: sv/gdf_pkg.sv
// ----------------------------------------------------------------------------
// GDF sample converter package
// Shared sample kind codes and the classified item passed front to back.
// ----------------------------------------------------------------------------
package gdf_pkg;

	localparam logic [3:0] KIND_I8   = 4'd0;
	localparam logic [3:0] KIND_U8   = 4'd1;
	localparam logic [3:0] KIND_I16  = 4'd2;
	localparam logic [3:0] KIND_U16  = 4'd3;
	localparam logic [3:0] KIND_I32  = 4'd4;
	localparam logic [3:0] KIND_U32  = 4'd5;
	localparam logic [3:0] KIND_I64  = 4'd6;
	localparam logic [3:0] KIND_U64  = 4'd7;
	localparam logic [3:0] KIND_F32  = 4'd8;
	localparam logic [3:0] KIND_F64  = 4'd9;
	localparam logic [3:0] KIND_F128 = 4'd10;
	localparam logic [3:0] KIND_OI16 = 4'd11;
	localparam logic [3:0] KIND_I12  = 4'd12;
	localparam logic [3:0] KIND_U12  = 4'd13;
	localparam logic [3:0] KIND_I24  = 4'd14;
	localparam logic [3:0] KIND_U24  = 4'd15;

	localparam logic [1:0] OP_INT  = 2'd0;
	localparam logic [1:0] OP_PASS = 2'd1;
	localparam logic [1:0] OP_DBL  = 2'd2;

	// Classified item: an operation, a sign and a 64-bit word (magnitude,
	// float32 bits or float64 bits).
	typedef struct packed {
		logic [1:0]  op;
		logic        neg;
		logic [63:0] word;
	} item_t;

endpackage

// File: sv/gdf_front.sv
// ----------------------------------------------------------------------------
// GDF front end
// Assembles sample bytes in file order (OI16 always little endian) and classifies them into an item.
// ----------------------------------------------------------------------------
module gdf_front (
	input  logic              file_le,
	input  logic [3:0]        kind,
	input  logic [63:0]       raw,
	output gdf_pkg::item_t    item
);

	function automatic logic [63:0] gather(input logic [63:0] r, input int n, input logic le);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < 8; i++) begin
			if (i < n) begin
				if (le) v[8*i +: 8] = r[8*i +: 8];
				else v = {v[55:0], r[8*i +: 8]};
			end
		end
		return v;
	endfunction

	logic [63:0] g2, g3, g4, g8, g2le, sv, oi;
	logic [11:0] p12;
	logic [6:0]  w;
	logic        sg;

	always_comb begin
		g2 = gather(raw, 2, file_le);
		g3 = gather(raw, 3, file_le);
		g4 = gather(raw, 4, file_le);
		g8 = gather(raw, 8, file_le);
		g2le = gather(raw, 2, 1'b1);
		oi = {48'd0, g2le[15:0] ^ 16'h8000};
		p12 = file_le ? g2[11:0] : g2[15:4];
		sv = '0;
		w = 7'd64;
		sg = 1'b0;
		item.op = gdf_pkg::OP_INT;
		case (kind)
			gdf_pkg::KIND_I8: begin sv = {56'd0, raw[7:0]}; w = 7'd8; sg = 1'b1; end
			gdf_pkg::KIND_U8: sv = {56'd0, raw[7:0]};
			gdf_pkg::KIND_I16: begin sv = g2; w = 7'd16; sg = 1'b1; end
			gdf_pkg::KIND_U16: sv = g2;
			gdf_pkg::KIND_I32: begin sv = g4; w = 7'd32; sg = 1'b1; end
			gdf_pkg::KIND_U32: sv = g4;
			gdf_pkg::KIND_I64: begin sv = g8; sg = 1'b1; end
			gdf_pkg::KIND_U64: sv = g8;
			gdf_pkg::KIND_F32: begin sv = g4; item.op = gdf_pkg::OP_PASS; end
			gdf_pkg::KIND_F64: begin sv = g8; item.op = gdf_pkg::OP_DBL; end
			gdf_pkg::KIND_F128: sv = '0;
			gdf_pkg::KIND_OI16: begin sv = oi; w = 7'd16; sg = 1'b1; end
			gdf_pkg::KIND_I12: begin sv = {52'd0, p12}; w = 7'd12; sg = 1'b1; end
			gdf_pkg::KIND_U12: sv = {52'd0, p12};
			gdf_pkg::KIND_I24: begin sv = g3; w = 7'd24; sg = 1'b1; end
			default: sv = g3;
		endcase
		// Sign extend to 64 bits, then take the magnitude.
		item.neg = 1'b0;
		item.word = sv;
		if (sg && w != 7'd64) begin
			if (sv[w[5:0] - 6'd1]) sv = sv | (~64'd0 << w[5:0]);
		end
		if (sg && sv[63]) begin
			item.neg = 1'b1;
			item.word = ~sv + 64'd1;
		end
	end

endmodule

// File: sv/gdf_queue.sv
// ----------------------------------------------------------------------------
// GDF item queue
// Two-entry queue between front and back; full throughput, registered ready.
// ----------------------------------------------------------------------------
module gdf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gdf_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output gdf_pkg::item_t out_item
);

	gdf_pkg::item_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: sv/gdf_back.sv
// ----------------------------------------------------------------------------
// GDF back end
// Two-stage conversion of a classified item to single precision bits.
// ----------------------------------------------------------------------------
module gdf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gdf_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    out_value
);

	// Stage 1: leading one position of integers.
	logic           v_s1;
	gdf_pkg::item_t it_s1;
	logic [5:0]     p_s1;
	logic           adv1, adv2;
	logic [5:0]     p_c;
	logic           v_s2;
	logic [31:0]    r_s2;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		p_c = '0;
		for (int i = 0; i < 64; i++) if (in_item.word[i]) p_c = 6'(i);
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			it_s1 <= in_item;
			p_s1 <= p_c;
		end
	end

	function automatic logic [63:0] rshift_rne(input logic [63:0] s, input logic [5:0] sh);
		logic [63:0] q, rem, half;
		q = s >> sh;
		rem = s & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 6'd1);
		if (rem > half || (rem == half && q[0])) q = q + 64'd1;
		return q;
	endfunction

	// Stage 2: normalize, round, pack.
	logic [31:0] r_c;
	logic [63:0] q, sig, bits;
	logic [10:0] e;
	logic [51:0] m;
	logic        sgn;
	always_comb begin
		r_c = '0;
		q = '0;
		bits = '0;
		sig = '0;
		e = it_s1.word[62:52];
		m = it_s1.word[51:0];
		sgn = it_s1.word[63];
		case (it_s1.op)
			gdf_pkg::OP_PASS: r_c = it_s1.word[31:0];
			gdf_pkg::OP_DBL: begin
				sig = {12'd1, m};
				if (e == 11'h7FF)
					r_c = (m == '0) ? {sgn, 31'h7F800000} : {sgn, 31'h7FC00000 | 31'(m >> 29)};
				else if (e == 11'd0) r_c = {sgn, 31'd0};
				else if (e > 11'd1150) r_c = {sgn, 31'h7F800000};
				else begin
					if (e >= 11'd897) bits = ({53'd0, e - 11'd897} << 23) + rshift_rne(sig, 6'd29);
					else if (e < 11'd866) bits = '0;
					else bits = rshift_rne(sig, 6'(11'd926 - e));
					if (bits >= 64'h7F800000) r_c = {sgn, 31'h7F800000};
					else r_c = {sgn, bits[30:0]};
				end
			end
			default: begin
				if (it_s1.word != '0) begin
					if (p_s1 <= 6'd23) q = it_s1.word << (6'd23 - p_s1);
					else q = rshift_rne(it_s1.word, p_s1 - 6'd23);
					bits = ({58'd0, p_s1} + 64'd126 << 23) + q;
					r_c = {it_s1.neg, bits[30:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) r_s2 <= r_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_value = r_s2;

endmodule

// File: sv/gdf_sample_to_float_converter.sv
// ----------------------------------------------------------------------------
// GDF sample to float converter
// Converts one raw sample and its kind code to an IEEE single per transfer.
// ----------------------------------------------------------------------------
// Usage: the input stream carries the eight sample bytes in s_axis_tdata, first
// byte in the low bits, and the sample kind in s_axis_tuser. Each input
// transfer produces exactly one output transfer on m_axis_tdata holding the
// single precision bit pattern. The front end assembles bytes and takes the
// integer magnitude in the accepting cycle; a two-entry queue follows, and
// the back end finds the leading one in one stage and rounds and packs in
// the next. A new sample is taken every cycle while the receiver is ready.
// When the receiver stalls, the back end stages and queue fill and
// s_axis_tready drops only when all are full. Reset clears all valid
// flags and sets file order to little endian; the cfg_wr/cfg_data port writes
// the byte order; the user must write it only while idle (not enforced).
// ----------------------------------------------------------------------------
module gdf_sample_to_float_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic        cfg_data,        // file_little_endian
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,    // raw_bytes
	input  logic [3:0]  s_axis_tuser,    // sample_kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata     // sample_value
);

	logic           file_le_q;
	gdf_pkg::item_t f_item, q_item;
	logic           q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) file_le_q <= 1'b1;
		else if (cfg_wr) file_le_q <= cfg_data;
	end

	gdf_front u_front (
		.file_le (file_le_q),
		.kind    (s_axis_tuser),
		.raw     (s_axis_tdata),
		.item    (f_item)
	);

	gdf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	gdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata)
	);

endmodule
